// File: rtl/prl_pkg.sv
// prl_pkg: shared types, codes and constants for the positional record list
// no dependencies
`default_nettype none
package prl_pkg;
  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned REC_W = 192;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_END   = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_END   = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_REVERSE   = 3'd6,
    ACT_DISPLAY   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  position;
    logic [31:0] roll_number;
    logic [63:0] name_head;
    logic [63:0] name_middle;
    logic [31:0] name_tail;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  list_count;
    logic        record_valid;
    logic [31:0] out_roll;
    logic [63:0] out_name_head;
    logic [63:0] out_name_middle;
    logic [31:0] out_name_tail;
    logic        last_result;
  } out_word_t;

  // back-end operation kinds, decoded in the back end from the queued word
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_REVERSE,
    OP_DISPLAY
  } op_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SHIFT,
    BS_SWAP_RD,
    BS_SWAP_WR,
    BS_DISP,
    BS_REPLY
  } bstate_t;
endpackage
`default_nettype wire

// File: rtl/prl_if.sv
// prl_if: valid/ready channel with a payload word
// depends on prl_pkg
`default_nettype none
interface prl_in_if;
  logic               valid;
  logic               ready;
  prl_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prl_out_if;
  logic               valid;
  logic               ready;
  prl_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/prl_ram.sv
// prl_ram: generic single write, single read ram with registered read
// no dependencies
`default_nettype none
module prl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/prl_front.sv
// prl_front: accepts input words and holds them in a two-entry queue
// depends on prl_pkg
`default_nettype none
module prl_front (
  input  wire logic               clk,
  input  wire logic               rst,
  prl_in_if.sink                  in_ch,
  output logic                    q_valid,
  output prl_pkg::in_word_t       q_data,
  input  wire logic               q_pop
);
  prl_pkg::in_word_t slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign in_ch.ready = (fill != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (fill != 2'd0);
  assign q_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_ch.data;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// File: rtl/prl_back.sv
// prl_back: carries out list operations on the record ram and emits result words
// depends on prl_pkg, prl_ram
`default_nettype none
module prl_back #(
  parameter int unsigned LIST_DEPTH = prl_pkg::LIST_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  prl_pkg::in_word_t  q_data,
  output logic               q_pop,
  prl_out_if.source          out_ch
);
  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  prl_pkg::bstate_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;       // walking index
  logic [CW-1:0] stop;      // end of walk
  logic [CW-1:0] hi;        // upper index for reverse
  logic          phase;     // read issued, data due next cycle
  logic          ins;
  logic [prl_pkg::REC_W-1:0] new_rec;
  logic [prl_pkg::REC_W-1:0] hold;
  logic [1:0]    status;

  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [prl_pkg::REC_W-1:0] wdata, rdata;

  prl_ram #(.WIDTH(prl_pkg::REC_W), .DEPTH(LIST_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // classify the queued word
  prl_pkg::op_t  dop;
  logic [1:0]    dstat;
  logic [CW-1:0] dpos;
  logic [CW-1:0] pos_ext;
  logic          full, empty;

  assign full = (count == CW'(LIST_DEPTH));
  assign empty = (count == '0);
  assign pos_ext = (32'(q_data.position) > LIST_DEPTH) ? CW'(LIST_DEPTH + 1)
                                                        : CW'(q_data.position);

  always_comb begin
    dop = prl_pkg::OP_NONE;
    dstat = prl_pkg::ST_OK;
    dpos = '0;
    unique case (prl_pkg::action_t'(q_data.action))
      prl_pkg::ACT_INS_FRONT, prl_pkg::ACT_INS_END, prl_pkg::ACT_INS_POS: begin
        if (full) dstat = prl_pkg::ST_FULL;
        else if (q_data.action == prl_pkg::ACT_INS_FRONT) begin
          dop = prl_pkg::OP_INSERT;
        end else if (q_data.action == prl_pkg::ACT_INS_END) begin
          dop = prl_pkg::OP_INSERT; dpos = count;
        end else if (q_data.position == 5'd0) dstat = prl_pkg::ST_BADPOS;
        else begin
          dop = prl_pkg::OP_INSERT;
          dpos = (pos_ext - 1'b1 > count) ? count : pos_ext - 1'b1;
        end
      end
      prl_pkg::ACT_DEL_FRONT, prl_pkg::ACT_DEL_END, prl_pkg::ACT_DEL_POS: begin
        if (empty) dstat = prl_pkg::ST_EMPTY;
        else if (q_data.action == prl_pkg::ACT_DEL_FRONT) begin
          dop = prl_pkg::OP_DELETE;
        end else if (q_data.action == prl_pkg::ACT_DEL_END) begin
          dop = prl_pkg::OP_DELETE; dpos = count - 1'b1;
        end else if (q_data.position == 5'd0 || pos_ext > count) begin
          dstat = prl_pkg::ST_BADPOS;
        end else begin
          dop = prl_pkg::OP_DELETE; dpos = pos_ext - 1'b1;
        end
      end
      prl_pkg::ACT_REVERSE: dop = prl_pkg::OP_REVERSE;
      default: begin
        if (empty) dstat = prl_pkg::ST_EMPTY;
        else dop = prl_pkg::OP_DISPLAY;
      end
    endcase
  end

  logic out_busy;
  logic emit_now;
  assign out_busy = out_ch.valid && !out_ch.ready;
  assign emit_now = !out_busy && ((state == prl_pkg::BS_REPLY) ||
                                  (state == prl_pkg::BS_DISP && phase));

  always_comb begin
    state_next = state;
    unique case (state)
      prl_pkg::BS_IDLE: begin
        if (q_valid) begin
          unique case (dop)
            prl_pkg::OP_INSERT, prl_pkg::OP_DELETE: state_next = prl_pkg::BS_SHIFT;
            prl_pkg::OP_REVERSE: state_next = prl_pkg::BS_SWAP_RD;
            prl_pkg::OP_DISPLAY: state_next = prl_pkg::BS_DISP;
            default: state_next = prl_pkg::BS_REPLY;
          endcase
        end
      end
      prl_pkg::BS_SHIFT: if (ins ? (idx == stop) : (idx + 1'b1 >= count)) begin
        state_next = prl_pkg::BS_REPLY;
      end
      prl_pkg::BS_SWAP_RD: begin
        if (idx >= hi) state_next = prl_pkg::BS_REPLY;
        else if (phase) state_next = prl_pkg::BS_SWAP_WR;
      end
      prl_pkg::BS_SWAP_WR: if (phase) state_next = prl_pkg::BS_SWAP_RD;
      prl_pkg::BS_DISP: if (phase && !out_busy && idx + 1'b1 == count) begin
        state_next = prl_pkg::BS_IDLE;
      end
      prl_pkg::BS_REPLY: if (!out_busy) state_next = prl_pkg::BS_IDLE;
      default: state_next = prl_pkg::BS_IDLE;
    endcase
  end

  // ram port and queue pop
  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    q_pop = 1'b0;
    unique case (state)
      prl_pkg::BS_IDLE: q_pop = q_valid;
      prl_pkg::BS_SHIFT: begin
        if (ins) begin
          // move entry idx-1 up to idx, new record lands at stop
          raddr = AW'(idx - 1'b1);
          if (idx == stop) begin
            we = 1'b1; wdata = new_rec;
          end else if (phase) begin
            we = 1'b1;
          end
        end else begin
          raddr = AW'(idx + 1'b1);
          we = phase && (idx + 1'b1 < count);
        end
      end
      prl_pkg::BS_SWAP_RD: begin
        raddr = phase ? hi[AW-1:0] : idx[AW-1:0];
      end
      prl_pkg::BS_SWAP_WR: begin
        // high entry into the low slot, then the held low entry into the high slot
        we = 1'b1;
        waddr = phase ? hi[AW-1:0] : idx[AW-1:0];
        wdata = phase ? hold : rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prl_pkg::BS_IDLE;
      count <= '0;
      out_ch.valid <= 1'b0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_now) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        prl_pkg::BS_IDLE: if (q_valid) begin
          status <= dstat;
          ins <= (dop == prl_pkg::OP_INSERT);
          new_rec <= {q_data.roll_number, q_data.name_head, q_data.name_middle,
                      q_data.name_tail};
          phase <= 1'b0;
          if (dop == prl_pkg::OP_INSERT) begin
            idx <= count; stop <= dpos;
          end else if (dop == prl_pkg::OP_DELETE) begin
            idx <= dpos;
          end else begin
            idx <= '0; hi <= count - 1'b1;
            if (empty) hi <= '0;
          end
        end
        prl_pkg::BS_SHIFT: begin
          if (ins) begin
            if (idx == stop) count <= count + 1'b1;
            else if (phase) begin idx <= idx - 1'b1; phase <= 1'b0; end
            else phase <= 1'b1;
          end else begin
            if (idx + 1'b1 >= count) count <= count - 1'b1;
            else if (phase) begin idx <= idx + 1'b1; phase <= 1'b0; end
            else phase <= 1'b1;
          end
        end
        prl_pkg::BS_SWAP_RD: begin
          // phase 0 reads low entry, phase 1 holds it and reads high entry
          if (idx < hi) begin
            if (phase) begin hold <= rdata; phase <= 1'b0; end
            else phase <= 1'b1;
          end
        end
        prl_pkg::BS_SWAP_WR: begin
          if (phase) begin
            hi <= hi - 1'b1;
            idx <= idx + 1'b1;
            phase <= 1'b0;
          end else phase <= 1'b1;
        end
        prl_pkg::BS_DISP: begin
          if (!phase) phase <= 1'b1;
          else if (!out_busy) begin
            out_ch.data <= '{status: prl_pkg::ST_OK, list_count: 5'(count),
              record_valid: 1'b1, out_roll: rdata[191:160],
              out_name_head: rdata[159:96], out_name_middle: rdata[95:32],
              out_name_tail: rdata[31:0], last_result: (idx + 1'b1 == count)};
            idx <= idx + 1'b1;
            phase <= 1'b0;
          end
        end
        prl_pkg::BS_REPLY: if (!out_busy) begin
          out_ch.data <= '{status: status, list_count: 5'(count), record_valid: 1'b0,
            out_roll: '0, out_name_head: '0, out_name_middle: '0, out_name_tail: '0,
            last_result: 1'b1};
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/positional_record_list_core.sv
// positional_record_list_core: top level of the record list engine
// depends on prl_pkg, prl_if, prl_front, prl_back, prl_ram
//
// Usage: input words arrive on in_ch (valid/ready), results leave on out_ch.
// Each word carries an action, position, roll number and 20-byte name.
// Every action but display gives one result word with status and count;
// display of a non-empty list gives one word per record in order, last_result on the final one.
// A two-entry queue in front accepts words while the back end works.
// Inserts and deletes shift one record at a time, reverse swaps one pair
// at a time and display reads one record at a time, all through the one
// write port and one read port of the ram that holds the store.
// Reset clears the count and the queue; record contents are left as is.
// When out_ch stalls, the back end holds its result and stops once its next
// result is ready; the queue fills and then in_ch.ready drops.
`default_nettype none
module positional_record_list_core #(
  parameter int unsigned LIST_DEPTH = prl_pkg::LIST_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  prl_in_if.sink    in_ch,
  prl_out_if.source out_ch
);
  logic              q_valid, q_pop;
  prl_pkg::in_word_t q_data;

  prl_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  prl_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// File: rtl/prl_checker.sv
// prl_checker: port-level checks for the record list core
// depends on prl_pkg
`default_nettype none
module prl_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [4:0] out_count,
  input wire logic out_rec,
  input wire logic [1:0] out_status
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= 5'd16) else $error("count too high");
  a_rec: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rec |-> out_status == prl_pkg::ST_OK) else $error("bad record status");
endmodule

bind positional_record_list_core prl_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_count(out_ch.data.list_count), .out_rec(out_ch.data.record_valid),
  .out_status(out_ch.data.status)
);
`default_nettype wire

// File: tb/positional_record_list_core_tb.sv
// positional_record_list_core_tb: self-checking bench for the record list engine
// depends on prl_pkg, prl_if and positional_record_list_core
`default_nettype none
module positional_record_list_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prl_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] roll;
    logic [63:0] head;
    logic [63:0] middle;
    logic [31:0] tail;
  } record_t;

  int unsigned mismatch_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  class list_scoreboard;
    record_t     records[$];
    out_word_t   pending[$];
    int unsigned words_in, words_out, displays, full_hits, bad_hits, empty_hits;

    function automatic out_word_t reply(input status_t st);
      out_word_t w;
      w = '0;
      w.status = st;
      w.list_count = 5'(records.size());
      w.last_result = 1'b1;
      return w;
    endfunction

    function automatic void note_input(input in_word_t w);
      record_t r;
      out_word_t o;
      int unsigned n, idx;
      status_t st;
      words_in++;
      n = records.size();
      r = {w.roll_number, w.name_head, w.name_middle, w.name_tail};
      st = ST_OK;
      case (action_t'(w.action))
        ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
          if (n >= DEPTH) st = ST_FULL;
          else if (w.action == ACT_INS_FRONT) records.push_front(r);
          else if (w.action == ACT_INS_END) records.push_back(r);
          else if (w.position == 0) st = ST_BADPOS;
          else begin
            idx = w.position - 1;
            if (idx > n) idx = n;
            records.insert(idx, r);
          end
        end
        ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_POS: begin
          if (n == 0) st = ST_EMPTY;
          else if (w.action == ACT_DEL_FRONT) records.delete(0);
          else if (w.action == ACT_DEL_END) records.delete(n - 1);
          else if (w.position == 0 || w.position > n) st = ST_BADPOS;
          else records.delete(w.position - 1);
        end
        ACT_REVERSE: records.reverse();
        default: begin
          displays++;
          if (n == 0) st = ST_EMPTY;
        end
      endcase
      if (st == ST_FULL) full_hits++;
      if (st == ST_BADPOS) bad_hits++;
      if (st == ST_EMPTY) empty_hits++;
      if (w.action == ACT_DISPLAY && n != 0) begin
        for (int unsigned i = 0; i < n; i++) begin
          o = reply(ST_OK);
          o.record_valid = 1'b1;
          {o.out_roll, o.out_name_head, o.out_name_middle, o.out_name_tail} = records[i];
          o.last_result = (i + 1 == n);
          pending.push_back(o);
        end
      end else pending.push_back(reply(st));
    endfunction

    task automatic check_result(input out_word_t got);
      out_word_t want;
      words_out++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", 64'(got.list_count), 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.list_count !== want.list_count)
        report_mismatch("list_count", got.list_count, want.list_count);
      if (got.record_valid !== want.record_valid)
        report_mismatch("record_valid", got.record_valid, want.record_valid);
      if (got.out_roll !== want.out_roll) report_mismatch("out_roll", got.out_roll, want.out_roll);
      if (got.out_name_head !== want.out_name_head)
        report_mismatch("out_name_head", got.out_name_head, want.out_name_head);
      if (got.out_name_middle !== want.out_name_middle)
        report_mismatch("out_name_middle", got.out_name_middle, want.out_name_middle);
      if (got.out_name_tail !== want.out_name_tail)
        report_mismatch("out_name_tail", got.out_name_tail, want.out_name_tail);
      if (got.last_result !== want.last_result)
        report_mismatch("last_result", got.last_result, want.last_result);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  prl_in_if  in_ch ();
  prl_out_if out_ch ();

  positional_record_list_core #(.LIST_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  list_scoreboard board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  // accepted words are noted and checked at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) board.note_input(in_ch.data);
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver stall, decided each falling edge
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic in_word_t random_word(input action_t act);
    in_word_t w;
    w.action = act;
    w.position = 5'($urandom_range(1, 17));
    if ($urandom_range(19) == 0) w.position = 5'($urandom_range(0, 31));
    w.roll_number = $urandom;
    w.name_head = {$urandom, $urandom};
    w.name_middle = {$urandom, $urandom};
    w.name_tail = $urandom;
    return w;
  endfunction

  // valid stays high after an accepted word so that words can follow back to back;
  // an idle cycle or wait_drained drops it
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(input action_t act, input logic [4:0] pos);
    in_word_t w;
    w = random_word(act);
    w.position = pos;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int unsigned count);
    action_t act;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      // lean toward inserts, turning some into deletes when long, to walk all fill levels
      if (pick < 45) act = action_t'($urandom_range(0, 2));
      else if (pick < 80) act = action_t'($urandom_range(3, 5));
      else if (pick < 88) act = ACT_REVERSE;
      else act = ACT_DISPLAY;
      if (board.records.size() > 12 && pick < 45 && $urandom_range(1)) act = ACT_DEL_POS;
      send_word(random_word(act));
    end
  endtask

  initial begin
    in_word_t w;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list cases, extremes, fill to full and drain
    send_op(ACT_DISPLAY, 1);
    send_op(ACT_DEL_FRONT, 1);
    send_op(ACT_DEL_POS, 1);
    send_op(ACT_REVERSE, 1);
    w = random_word(ACT_INS_END);
    w.roll_number = 32'h8000_0000;
    w.name_head = '1; w.name_middle = '0; w.name_tail = '1;
    send_word(w);
    send_op(ACT_REVERSE, 1);
    send_op(ACT_DEL_END, 1);
    w.action = ACT_INS_POS; w.position = 1;
    w.roll_number = 32'h7fff_ffff; w.name_head = '0; w.name_middle = '1; w.name_tail = '0;
    send_word(w);
    send_op(ACT_INS_POS, 0);
    send_op(ACT_INS_POS, 31);
    send_op(ACT_DEL_POS, 0);
    send_op(ACT_DEL_POS, 17);
    send_op(ACT_DEL_POS, 2);
    for (int i = 0; i < 14; i++) send_op(ACT_INS_FRONT, 1);
    send_op(ACT_INS_END, 1);
    send_op(ACT_INS_POS, 17);
    send_op(ACT_REVERSE, 1);
    send_op(ACT_DISPLAY, 1);
    for (int i = 0; i < 16; i++) send_op(ACT_DEL_POS, 5'd16 - i[4:0]);

    send_idle_pct = 30; recv_idle_pct = 55;
    random_phase(120);
    wait_drained();
    send_idle_pct = 55; recv_idle_pct = 30;
    random_phase(120);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(110);

    wait_drained();
    repeat (2 * DEPTH + 20) @(negedge clk);
    $display("covered %0d words in, %0d results out, %0d displays", board.words_in,
             board.words_out, board.displays);
    $display("status hits: full %0d, bad position %0d, empty %0d", board.full_hits,
             board.bad_hits, board.empty_hits);
    if (mismatch_count == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: positional_record_list_core.f
rtl/prl_pkg.sv
rtl/prl_if.sv
rtl/prl_ram.sv
rtl/prl_front.sv
rtl/prl_back.sv
rtl/positional_record_list_core.sv
rtl/prl_checker.sv
tb/positional_record_list_core_tb.sv
